@@ rtl/first_fit_heap_allocator_defines.svh @@
// Assertion macros shared by the first-fit heap allocator RTL.
// Depends on a clock named clk and an active-low reset named rst_n in scope.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define FFHA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication, checked outside reset.
`define FFHA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`endif

@@ rtl/ffha_pkg.sv @@
// Package for the first-fit heap allocator: sizes, codes and the table entry type.
// Has no dependencies.
`default_nettype none
package ffha_pkg;
  localparam int MAX_BLOCKS   = 64;
  localparam int IDX_W        = $clog2(MAX_BLOCKS);
  localparam int CNT_W        = IDX_W + 1;
  localparam int ALIGN_BYTES  = 16;
  localparam int HEADER_BYTES = 40;
  localparam int PAGE_BYTES   = 4096;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_BAD_REQ = 2'd1;
  localparam logic [1:0] ST_NO_SPACE = 2'd2;
  localparam logic [1:0] ST_BAD_FREE = 2'd3;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] size;
    logic        free;
  } entry_t;
endpackage
`default_nettype wire

@@ rtl/ffha_table.sv @@
// Block table memory: one write port and one registered read port.
// Depends on ffha_pkg for the entry type and depth.
`default_nettype none
module ffha_table (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [ffha_pkg::IDX_W-1:0]  wr_addr,
  input  wire ffha_pkg::entry_t            wr_data,
  input  wire logic [ffha_pkg::IDX_W-1:0]  rd_addr,
  output      ffha_pkg::entry_t            rd_data
);
  ffha_pkg::entry_t mem [ffha_pkg::MAX_BLOCKS];
  ffha_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;
endmodule
`default_nettype wire

@@ rtl/first_fit_heap_allocator.sv @@
// Top level of the first-fit heap allocator: sequencer, counters and output register.
// Depends on ffha_pkg, ffha_table and first_fit_heap_allocator_defines.svh.
//
// Channel | Direction | Contents
// in_     | slave     | tuser: operation; tdata: request_bytes, free_offset
// out_    | master    | tdata: status, payload_offset, used_total, mapped_total
// cfg_    | write     | heap extent limit
//
// An item walks the block table one entry at a time through the single table read
// port, a read state then an evaluate state per entry; a new request waits until done.
// Reset is synchronous; no clearing pass is needed since only entries below the
// block count are read. The result waits in an output register until taken.
`default_nettype none
`include "first_fit_heap_allocator_defines.svh"
module first_fit_heap_allocator (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output      logic         in_tready,
  input  wire logic [63:0]  in_tdata,   // request_bytes[31:0], free_offset[63:32]
  input  wire logic         in_tuser,   // operation
  output      logic         out_tvalid,
  input  wire logic         out_tready,
  output      logic [103:0] out_tdata,  // status, payload_offset, used_total, mapped_total
  input  wire logic         cfg_wr_en,
  input  wire logic [31:0]  cfg_wr_data
);
  localparam logic [3:0] S_IDLE = 4'd0, S_SCAN_RD = 4'd1, S_SCAN_EV = 4'd2,
    S_SHUP_RD = 4'd3, S_SHUP_WR = 4'd4, S_SPLIT_HI = 4'd5, S_SPLIT_LO = 4'd6,
    S_APPEND = 4'd7, S_NEXT_RD = 4'd8, S_NEXT_EV = 4'd9, S_SHDN_CHK = 4'd10,
    S_SHDN_RD = 4'd11, S_SHDN_WR = 4'd12, S_PREV_CHK = 4'd13, S_PREV_EV = 4'd14,
    S_FIN = 4'd15;
  localparam int IW = ffha_pkg::IDX_W;
  localparam int CW = ffha_pkg::CNT_W;
  localparam logic [31:0] HDR = 32'(ffha_pkg::HEADER_BYTES);
  localparam logic [32:0] AL_M1 = 33'(ffha_pkg::ALIGN_BYTES - 1);
  localparam logic [33:0] PG_M1 = 34'(ffha_pkg::PAGE_BYTES - 1);
  localparam logic [CW-1:0] MAXC = CW'(ffha_pkg::MAX_BLOCKS);

  logic [3:0]    state_r, state_nxt;
  logic          op_r, op_nxt, phase_r, phase_nxt;
  logic [31:0]   sz_r, sz_nxt, key_r, key_nxt;
  logic [CW-1:0] idx_r, idx_nxt, k_r, k_nxt, cnt_r, cnt_nxt;
  ffha_pkg::entry_t cur_r, cur_nxt;
  logic [31:0]   top_r, top_nxt, map_r, map_nxt, used_r, used_nxt, lim_r;
  logic [1:0]    pst_r, pst_nxt;
  logic [31:0]   poff_r, poff_nxt;
  logic          ov_r, ov_nxt;
  logic [103:0]  od_r, od_nxt;

  logic          we;
  logic [IW-1:0] wa, ra;
  ffha_pkg::entry_t wd, rd;
  logic [32:0]   sz_rnd;
  logic [33:0]   end_w, tgt_w, need_w;

  ffha_table u_table (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign sz_rnd = ({1'b0, in_tdata[31:0]} + AL_M1) & ~AL_M1;
  assign end_w  = {2'b0, top_r} + {2'b0, HDR} + {2'b0, sz_r};
  assign tgt_w  = (end_w + PG_M1) & ~PG_M1;
  assign need_w = {2'b0, sz_r} + {2'b0, HDR} + 34'(ffha_pkg::ALIGN_BYTES);

  always_comb begin
    state_nxt = state_r; op_nxt = op_r; phase_nxt = phase_r; sz_nxt = sz_r;
    key_nxt = key_r; idx_nxt = idx_r; k_nxt = k_r; cnt_nxt = cnt_r; cur_nxt = cur_r;
    top_nxt = top_r; map_nxt = map_r; used_nxt = used_r; pst_nxt = pst_r;
    poff_nxt = poff_r; ov_nxt = ov_r; od_nxt = od_r;
    we = 1'b0; wa = idx_r[IW-1:0]; wd = cur_r; ra = idx_r[IW-1:0];
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt = in_tuser; idx_nxt = '0; pst_nxt = ffha_pkg::ST_DONE; poff_nxt = '0;
          sz_nxt = sz_rnd[31:0];
          key_nxt = in_tdata[63:32] - HDR;
          if (!in_tuser) begin
            if (in_tdata[31:0] == 32'd0 || sz_rnd[32]) begin
              pst_nxt = ffha_pkg::ST_BAD_REQ; state_nxt = S_FIN;
            end else if (cnt_r == '0) begin
              state_nxt = S_APPEND;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end else if (in_tdata[63:32] < HDR || in_tdata[63:32] >= top_r) begin
            pst_nxt = ffha_pkg::ST_BAD_FREE; state_nxt = S_FIN;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        state_nxt = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        if (!op_r && rd.free && rd.size >= sz_r) begin
          cur_nxt = rd;
          poff_nxt = rd.start + HDR;
          if ({2'b0, rd.size} >= need_w && cnt_r < MAXC) begin
            k_nxt = cnt_r;
            state_nxt = (cnt_r == idx_r + 1'b1) ? S_SPLIT_HI : S_SHUP_RD;
          end else begin
            we = 1'b1; wd = '{start: rd.start, size: rd.size, free: 1'b0};
            used_nxt = used_r + rd.size; state_nxt = S_FIN;
          end
        end else if (op_r && rd.start == key_r) begin
          if (rd.free) begin
            pst_nxt = ffha_pkg::ST_BAD_FREE; state_nxt = S_FIN;
          end else begin
            cur_nxt = '{start: rd.start, size: rd.size, free: 1'b1};
            we = 1'b1; wd = '{start: rd.start, size: rd.size, free: 1'b1};
            used_nxt = used_r - rd.size;
            state_nxt = (idx_r + 1'b1 < cnt_r) ? S_NEXT_RD : S_PREV_CHK;
          end
        end else begin
          idx_nxt = idx_r + 1'b1;
          if (idx_r + 1'b1 == cnt_r) begin
            if (op_r) begin
              pst_nxt = ffha_pkg::ST_BAD_FREE; state_nxt = S_FIN;
            end else begin
              state_nxt = S_APPEND;
            end
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SHUP_RD: begin
        ra = IW'(k_r - 1'b1); state_nxt = S_SHUP_WR;
      end
      S_SHUP_WR: begin
        we = 1'b1; wa = k_r[IW-1:0]; wd = rd; k_nxt = k_r - 1'b1;
        state_nxt = (k_r - 1'b1 == idx_r + 1'b1) ? S_SPLIT_HI : S_SHUP_RD;
      end
      S_SPLIT_HI: begin
        we = 1'b1; wa = IW'(idx_r + 1'b1);
        wd = '{start: cur_r.start + HDR + sz_r, size: cur_r.size - sz_r - HDR, free: 1'b1};
        state_nxt = S_SPLIT_LO;
      end
      S_SPLIT_LO: begin
        we = 1'b1; wd = '{start: cur_r.start, size: sz_r, free: 1'b0};
        cnt_nxt = cnt_r + 1'b1; used_nxt = used_r + sz_r; state_nxt = S_FIN;
      end
      S_APPEND: begin
        if (cnt_r >= MAXC || end_w > {2'b0, lim_r} || tgt_w[33:32] != 2'b0) begin
          pst_nxt = ffha_pkg::ST_NO_SPACE;
        end else begin
          if (tgt_w[31:0] > map_r) begin
            map_nxt = tgt_w[31:0];
          end
          we = 1'b1; wa = cnt_r[IW-1:0]; wd = '{start: top_r, size: sz_r, free: 1'b0};
          cnt_nxt = cnt_r + 1'b1; top_nxt = end_w[31:0];
          used_nxt = used_r + sz_r; poff_nxt = top_r + HDR;
        end
        state_nxt = S_FIN;
      end
      S_NEXT_RD: begin
        ra = IW'(idx_r + 1'b1); state_nxt = S_NEXT_EV;
      end
      S_NEXT_EV: begin
        if (rd.free) begin
          cur_nxt.size = cur_r.size + HDR + rd.size;
          we = 1'b1; wd = '{start: cur_r.start, size: cur_r.size + HDR + rd.size, free: 1'b1};
          k_nxt = idx_r + 1'b1; phase_nxt = 1'b0; state_nxt = S_SHDN_CHK;
        end else begin
          state_nxt = S_PREV_CHK;
        end
      end
      S_SHDN_CHK: begin
        if (k_r + 1'b1 < cnt_r) begin
          state_nxt = S_SHDN_RD;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
          state_nxt = phase_r ? S_FIN : S_PREV_CHK;
        end
      end
      S_SHDN_RD: begin
        ra = IW'(k_r + 1'b1); state_nxt = S_SHDN_WR;
      end
      S_SHDN_WR: begin
        we = 1'b1; wa = k_r[IW-1:0]; wd = rd; k_nxt = k_r + 1'b1; state_nxt = S_SHDN_CHK;
      end
      S_PREV_CHK: begin
        ra = IW'(idx_r - 1'b1);
        state_nxt = (idx_r != '0) ? S_PREV_EV : S_FIN;
      end
      S_PREV_EV: begin
        if (rd.free) begin
          we = 1'b1; wa = IW'(idx_r - 1'b1);
          wd = '{start: rd.start, size: rd.size + HDR + cur_r.size, free: 1'b1};
          k_nxt = idx_r; phase_nxt = 1'b1; state_nxt = S_SHDN_CHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1;
          od_nxt = {6'b0, map_r, used_r, poff_r, pst_r};
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; top_r <= '0; map_r <= '0; used_r <= '0;
      lim_r <= 32'hFFFF_FFFF; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; top_r <= top_nxt; map_r <= map_nxt;
      used_r <= used_nxt; ov_r <= ov_nxt;
      if (cfg_wr_en) begin
        lim_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r <= op_nxt; phase_r <= phase_nxt; sz_r <= sz_nxt; key_r <= key_nxt;
    idx_r <= idx_nxt; k_r <= k_nxt; cur_r <= cur_nxt; pst_r <= pst_nxt;
    poff_r <= poff_nxt; od_r <= od_nxt;
  end

  `FFHA_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= MAXC)
  `FFHA_ASSERT_NOW(a_map_page, 1'b1, map_r[11:0] == 12'd0)
  `FFHA_ASSERT_NOW(a_top_mapped, 1'b1, top_r <= map_r)
  `FFHA_ASSERT_NEXT(a_busy_after_take, in_tvalid && in_tready, !in_tready)
endmodule
`default_nettype wire
